>>> hw/rtl/ksbxc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed stream byte XOR cipher package
// Shared widths, register indexes and key constants of the cipher core.
// ----------------------------------------------------------------------------
package ksbxc_pkg;

    // Field and register widths.
    localparam int DataWidth   = 8;
    localparam int PosWidth    = 64;
    localparam int KeyRegWidth = 64;
    localparam int CfgIdxWidth = 3;
    localparam int FileIdxWidth = 5;

    // The file key has sixteen programmable bytes and a fixed last byte.
    localparam int unsigned FileKeyLen = 17;
    localparam logic [DataWidth-1:0] FileKeyLast = 8'h6B;

    // Configuration register indexes.
    typedef enum logic [CfgIdxWidth-1:0] {
        REG_SLOT_KEY_LOW  = 3'd0,
        REG_SLOT_KEY_HIGH = 3'd1,
        REG_FILE_KEY_LOW  = 3'd2,
        REG_FILE_KEY_HIGH = 3'd3,
        REG_DECRYPT_MODE  = 3'd4
    } cfg_index_t;

endpackage : ksbxc_pkg

>>> hw/rtl/keyed_stream_byte_xor_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed stream byte XOR cipher core
// Transforms one byte per transfer with position-dependent slot, file and
// offset keys, in encrypt or decrypt order.
// ----------------------------------------------------------------------------
// Throughput is one byte per clock cycle while the output is not stalled.
// Each input is captured in an input register together with a partial byte
// sum of its start offset; the processing stage then resolves the run
// position and the position mod 17 file index, selects the three key bytes,
// applies the cipher steps and loads the output register. The position and
// file index counters advance in that same stage, once per byte. The user
// must write key and mode registers through the cfg port only while no byte
// is in flight; the core does not enforce this. Decrypt order is set by reset.
module keyed_stream_byte_xor_cipher_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [ksbxc_pkg::CfgIdxWidth-1:0]   cfg_addr,
    input  logic [ksbxc_pkg::KeyRegWidth-1:0]   cfg_wdata,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [71:0]                         s_tdata,  // [7:0] data_in, [71:8] start_offset
    input  logic                                s_tuser,  // [0] start_req
    // Output stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata   // [7:0] data_out
);
    import ksbxc_pkg::*;

    // Configuration registers.
    logic [KeyRegWidth-1:0] slot_key_low_reg;
    logic [KeyRegWidth-1:0] slot_key_high_reg;
    logic [KeyRegWidth-1:0] file_key_low_reg;
    logic [KeyRegWidth-1:0] file_key_high_reg;
    logic                   decrypt_mode_reg;

    // Input stage.
    logic                   in_valid_reg;
    logic [DataWidth-1:0]   in_data_reg;
    logic                   in_start_reg;
    logic [PosWidth-1:0]    in_offset_reg;
    logic [10:0]            in_bsum_reg;
    logic [10:0]            bsum_next;

    // Run state.
    logic [PosWidth-1:0]     position_reg;
    logic [FileIdxWidth-1:0] file_index_reg;

    // Output stage.
    logic                   out_valid_reg;
    logic [DataWidth-1:0]   out_data_reg;
    logic [DataWidth-1:0]   out_data_next;

    // Datapath signals.
    logic                    s_xfer;
    logic                    proc_en;
    logic [8:0]              fold_sum;
    logic signed [5:0]       mod_diff;
    logic [FileIdxWidth-1:0] offset_mod;
    logic [PosWidth-1:0]     cur_pos;
    logic [FileIdxWidth-1:0] cur_fidx;
    logic [DataWidth-1:0]    off_key;
    logic [DataWidth-1:0]    slot_byte;
    logic [DataWidth-1:0]    file_byte;
    logic [127:0]            slot_bytes;
    logic [127:0]            file_bytes;
    logic [DataWidth-1:0]    enc_mix;
    logic [DataWidth-1:0]    dec_mix;
    logic [DataWidth-1:0]    enc_fold;
    logic [DataWidth-1:0]    dec_fold;

    // Handshake: the processing stage moves when the output register is free.
    assign proc_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_en;
    assign s_xfer   = s_tvalid && s_tready;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_key_low_reg  <= '0;
            slot_key_high_reg <= '0;
            file_key_low_reg  <= '0;
            file_key_high_reg <= '0;
            decrypt_mode_reg  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_SLOT_KEY_LOW:  slot_key_low_reg  <= cfg_wdata;
                REG_SLOT_KEY_HIGH: slot_key_high_reg <= cfg_wdata;
                REG_FILE_KEY_LOW:  file_key_low_reg  <= cfg_wdata;
                REG_FILE_KEY_HIGH: file_key_high_reg <= cfg_wdata;
                REG_DECRYPT_MODE:  decrypt_mode_reg  <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // Since 256 is 1 mod 17, the byte sum of the offset keeps its residue.
    always_comb
    begin
        bsum_next = '0;
        for (int i = 0; i < PosWidth / 8; i++)
        begin
            bsum_next = bsum_next + {3'b000, s_tdata[8 + 8*i +: 8]};
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_data_reg   <= s_tdata[7:0];
            in_offset_reg <= s_tdata[71:8];
            in_start_reg  <= s_tuser;
            in_bsum_reg   <= bsum_next;
        end
    end

    // Finish the mod 17 reduction: fold once more by 256, then use 16 = -1.
    assign fold_sum = {1'b0, in_bsum_reg[7:0]} + {6'b0, in_bsum_reg[10:8]};
    assign mod_diff = $signed({2'b00, fold_sum[3:0]}) - $signed({1'b0, fold_sum[8:4]});
    always_comb
    begin
        if (mod_diff < 0)
        begin
            offset_mod = FileIdxWidth'(mod_diff + 6'sd17);
        end
        else
        begin
            offset_mod = FileIdxWidth'(mod_diff);
        end
    end

    // A start transfer reloads the run position; otherwise the counters go on.
    assign cur_pos  = in_start_reg ? in_offset_reg : position_reg;
    assign cur_fidx = in_start_reg ? offset_mod : file_index_reg;

    // Key byte selection.
    assign slot_bytes = {slot_key_high_reg, slot_key_low_reg};
    assign file_bytes = {file_key_high_reg, file_key_low_reg};
    assign off_key    = cur_pos[7:0] ^ cur_pos[15:8] ^ cur_pos[23:16] ^ cur_pos[31:24];
    assign slot_byte  = slot_bytes[8*cur_pos[3:0] +: 8];
    assign file_byte  = (cur_fidx == FileIdxWidth'(FileKeyLen - 1)) ?
                        FileKeyLast : file_bytes[8*cur_fidx[3:0] +: 8];

    // Cipher steps: the nibble fold sits between the key XORs in either order.
    assign enc_mix  = in_data_reg ^ off_key ^ slot_byte;
    assign enc_fold = enc_mix ^ {enc_mix[3:0], 4'b0000};
    assign dec_mix  = in_data_reg ^ file_byte;
    assign dec_fold = dec_mix ^ {dec_mix[3:0], 4'b0000};
    assign out_data_next = decrypt_mode_reg ? (dec_fold ^ slot_byte ^ off_key)
                                            : (enc_fold ^ file_byte);

    // Run state advances once per processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            file_index_reg <= '0;
        end
        else if (proc_en)
        begin
            position_reg <= cur_pos + PosWidth'(1);
            if (cur_fidx >= FileIdxWidth'(FileKeyLen - 1))
            begin
                file_index_reg <= '0;
            end
            else
            begin
                file_index_reg <= cur_fidx + FileIdxWidth'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule : keyed_stream_byte_xor_cipher_core

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed stream byte XOR cipher core testbench
// Streams bytes through the cipher core in encrypt and decrypt order under
// several key settings and compares every output byte with a cycle-free
// software keystream model. Both sides pause at random but in one phase.
// ----------------------------------------------------------------------------
module tb;

    import ksbxc_pkg::*;

    // Cycles without any transfer before the run is abandoned.
    localparam int unsigned StallLimit = 5000;
    // Pipeline depth of the core, used for the pause after draining.
    localparam int unsigned PipeDepth = 2;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CfgIdxWidth-1:0]  cfg_addr = '0;
    logic [KeyRegWidth-1:0]  cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [71:0]             s_tdata = '0;   // [7:0] data_in, [71:8] start_offset
    logic                    s_tuser = 1'b0; // [0] start_req
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [7:0]              m_tdata;        // [7:0] data_out

    // Software copy of the key registers and the running keystream position.
    logic [63:0]             slot_key_lo = '0;
    logic [63:0]             slot_key_hi = '0;
    logic [63:0]             file_key_lo = '0;
    logic [63:0]             file_key_hi = '0;
    logic                    decrypt_order = 1'b1;
    logic [PosWidth-1:0]     stream_pos = '0;
    logic [FileIdxWidth-1:0] file_slot = '0;

    logic [7:0]              expected_bytes[$];
    int unsigned             error_count = 0;
    int unsigned             bytes_checked = 0;
    int unsigned             key_settings = 0;
    int unsigned             quiet_cycles = 0;
    bit                      steady_flow = 1'b0;

    keyed_stream_byte_xor_cipher_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Free-running 10 ns clock.
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // One byte of a 16-byte key held in two 64-bit words.
    function automatic logic [7:0] key_byte(logic [63:0] lo, logic [63:0] hi, logic [3:0] idx);
        logic [63:0] word;
        word = idx[3] ? hi : lo;
        return word[idx[2:0]*8 +: 8];
    endfunction

    // Transforms one accepted byte and advances the keystream position.
    function automatic logic [7:0] next_cipher_byte(logic [7:0] din, logic start,
                                                     logic [63:0] offset);
        logic [31:0] pos_low;
        logic [7:0]  pos_key;
        logic [7:0]  slot_b;
        logic [7:0]  file_b;
        logic [7:0]  v;
        if (start)
        begin
            stream_pos = offset;
            file_slot  = FileIdxWidth'(offset % FileKeyLen);
        end
        if (file_slot >= FileIdxWidth'(FileKeyLen))
            file_slot = '0;
        pos_low = stream_pos[31:0];
        pos_key = pos_low[7:0] ^ pos_low[15:8] ^ pos_low[23:16] ^ pos_low[31:24];
        slot_b  = key_byte(slot_key_lo, slot_key_hi, stream_pos[3:0]);
        file_b  = (file_slot == FileIdxWidth'(FileKeyLen - 1)) ? FileKeyLast
                                                               : key_byte(file_key_lo,
                                                                          file_key_hi,
                                                                          file_slot[3:0]);
        v = din;
        if (decrypt_order)
        begin
            v = v ^ file_b;
            v = v ^ {v[3:0], 4'b0000};
            v = v ^ slot_b ^ pos_key;
        end
        else
        begin
            v = v ^ pos_key ^ slot_b;
            v = v ^ {v[3:0], 4'b0000};
            v = v ^ file_b;
        end
        stream_pos = stream_pos + PosWidth'(1);
        file_slot  = (file_slot == FileIdxWidth'(FileKeyLen - 1)) ? '0
                                                                  : file_slot + FileIdxWidth'(1);
        return v;
    endfunction

    // Start offsets that favor the position wrap and the 32-bit boundary.
    function automatic logic [63:0] pick_offset();
        unique case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 300));
            2: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
            default: return {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(0, 40))};
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        error_count++;
        $display("tb: mismatch at %0t: %s, got %02h, expected %02h", $time, what, got, want);
    endtask

    // Sends one byte; returns at the falling edge after its transfer.
    task automatic send_byte(logic [7:0] din, logic start, logic [63:0] offset);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {8'($urandom), $urandom, $urandom};
            s_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {offset, din};
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_bytes.push_back(next_cipher_byte(din, start, offset));
        @(negedge clk);
    endtask

    // Stops the input stream and waits until every output byte has arrived.
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (PipeDepth + 2) @(negedge clk);
    endtask

    // One register write; the caller lowers the write enable afterwards.
    task automatic put_reg(cfg_index_t idx, logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        unique case (idx)
            REG_SLOT_KEY_LOW:  slot_key_lo = value;
            REG_SLOT_KEY_HIGH: slot_key_hi = value;
            REG_FILE_KEY_LOW:  file_key_lo = value;
            REG_FILE_KEY_HIGH: file_key_hi = value;
            REG_DECRYPT_MODE:  decrypt_order = value[0];
            default: ;
        endcase
    endtask

    // Writes all key and mode registers while the core is idle.
    task automatic program_keys(logic [63:0] slo, logic [63:0] shi, logic [63:0] flo,
                                logic [63:0] fhi, logic mode);
        drain_stream();
        put_reg(REG_SLOT_KEY_LOW, slo);
        put_reg(REG_SLOT_KEY_HIGH, shi);
        put_reg(REG_FILE_KEY_LOW, flo);
        put_reg(REG_FILE_KEY_HIGH, fhi);
        put_reg(REG_DECRYPT_MODE, {$urandom, 31'($urandom), mode});
        cfg_wr_en <= 1'b0;
        key_settings++;
    endtask

    // Reset values: decrypt order, zero keys, position 0 without a start.
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0, {$urandom, $urandom});
        send_byte(8'hFF, 1'b0, {$urandom, $urandom});
        send_byte(8'hA5, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        key_settings++;
    endtask

    // Extreme keys and offsets in both orders, including the position wrap
    // and the fixed last byte of the file key.
    task automatic test_directed_extremes();
        program_keys('1, '1, '1, '1, 1'b0);
        send_byte(8'h00, 1'b1, 64'd0);
        send_byte(8'hFF, 1'b0, 64'd0);
        send_byte(8'h3C, 1'b1, 64'd16);
        send_byte(8'hC3, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE);
        for (int i = 0; i < 4; i++)
            send_byte(8'(i * 8'h55), 1'b0, '0);
        program_keys(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
                     64'h8877_6655_4433_2211, 64'h00FF_EEDD_CCBB_AA99, 1'b1);
        send_byte(8'h00, 1'b1, 64'h0000_0000_FFFF_FFFE);
        send_byte(8'hFF, 1'b0, '1);
        send_byte(8'h5A, 1'b0, '1);
        send_byte(8'h81, 1'b1, 64'd33);
        send_byte(8'h7E, 1'b0, 64'd0);
        send_byte(8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h00, 1'b0, 64'd0);
        send_byte(8'h12, 1'b0, 64'd0);
        program_keys('0, '0, '0, '0, 1'b0);
        send_byte(8'hFF, 1'b1, 64'h8000_0000_0000_0010);
        send_byte(8'h00, 1'b0, 64'h5555_5555_5555_5555);
    endtask

    // Runs of bytes under several key settings; most runs begin with a
    // start, some continue the previous run, a few are single bytes.
    task automatic test_random_runs();
        int unsigned sent;
        int unsigned run_len;
        int unsigned kind;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: program_keys('0, '0, '0, '0, 1'b0);
                1: program_keys('1, '1, '1, '1, 1'b1);
                default: program_keys({$urandom, $urandom}, {$urandom, $urandom},
                                      {$urandom, $urandom}, {$urandom, $urandom},
                                      1'($urandom_range(0, 1)));
            endcase
            steady_flow = (phase == 3);
            sent = 0;
            while (sent < 75)
            begin
                kind = $urandom_range(0, 99);
                run_len = (kind < 85) ? $urandom_range(1, 30) : 1;
                if (kind < 75)
                begin
                    send_byte(8'($urandom), 1'b1, pick_offset());
                    sent++;
                end
                for (int i = 0; i < run_len; i++)
                begin
                    send_byte(8'($urandom), 1'b0, {$urandom, $urandom});
                    sent++;
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    // Output side: ready runs broken by random stalls.
    initial
    begin
        int unsigned run;
        int unsigned stall;
        @(negedge clk);
        forever
        begin
            if (steady_flow)
            begin
                m_tready <= 1'b1;
                @(negedge clk);
            end
            else
            begin
                run = $urandom_range(1, 20);
                m_tready <= 1'b1;
                repeat (run) @(negedge clk);
                stall = pick_gap();
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
        end
    end

    // Output check against the oldest expected byte, and the watchdog.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("tb: FAIL");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch("output transfer with no byte pending", m_tdata, 8'h00);
            else
            begin
                if (m_tdata !== expected_bytes[0])
                    report_mismatch("data_out", m_tdata, expected_bytes[0]);
                void'(expected_bytes.pop_front());
                bytes_checked++;
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_directed_extremes();
        test_random_runs();
        drain_stream();
        $display("tb: %0d output bytes checked under %0d key settings", bytes_checked,
                 key_settings);
        $display("tb: covered both cipher orders, run starts, continuations and wraps");
        if (error_count == 0 && expected_bytes.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule : tb
